>>> rtl/core/rotated_rect_circle_edge_hit_defines.svh
// Assertion macros used by the top-level RTL file of the block.
`ifndef ROTATED_RECT_CIRCLE_EDGE_HIT_DEFINES_SVH
`define ROTATED_RECT_CIRCLE_EDGE_HIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRCEH_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRCEH_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/rrceh_pkg.sv
package rrceh_pkg;

	localparam int COORD_WIDTH        = 16;
	localparam int TRIG_FRACTION_BITS = 14;

	// Field and datapath widths
	localparam int SIZE_W  = COORD_WIDTH - 1;
	localparam int ANGLE_W = 9;
	localparam int RES_W   = 7;
	localparam int TRIG_W  = TRIG_FRACTION_BITS + 2;
	localparam int PROD_W  = SIZE_W + 1 + TRIG_W;
	localparam int SUMK_W  = PROD_W + 2;
	localparam int PNT_W   = COORD_WIDTH + 2;
	localparam int R2_W    = 2 * COORD_WIDTH;
	localparam int DIF_W   = PNT_W + 1;
	localparam int MUL_W   = 2 * DIF_W;
	localparam int SUM_W   = MUL_W + 1;
	localparam int MAG_W   = SUM_W - 1;

	// Pipeline depth from input register to result register
	localparam int PIPE_DEPTH = 10;

	// Angle constants in degrees
	localparam logic [ANGLE_W-1:0] ANG_FULL  = ANGLE_W'(360);
	localparam logic [ANGLE_W-1:0] ANG_HALF  = ANGLE_W'(180);
	localparam logic [ANGLE_W-1:0] ANG_3QTR  = ANGLE_W'(270);
	localparam logic [ANGLE_W-1:0] ANG_QTR   = ANGLE_W'(90);
	localparam int                 QUARTER   = 90;

	// Series setup for the sine table
	localparam logic [63:0] PI_Q30       = 64'hC90FDAA2;
	localparam longint      ONE_Q30      = longint'(1) << 30;
	localparam int          SERIES_TERMS = 8;

	typedef logic [TRIG_W-1:0] sin_tab_t [0:QUARTER];

	typedef struct packed {
		logic signed [PNT_W-1:0] x;
		logic signed [PNT_W-1:0] y;
	} point_t;

	// sin(k deg) for k = 0..90, Taylor series in Q30, rounded to trig format
	function automatic sin_tab_t sin_table_init();
		sin_tab_t    tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint      acc;
		for (int k = 0; k <= QUARTER; k++) begin
			x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n[0]) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > ONE_Q30) begin
				acc = ONE_Q30;
			end
			v = 64'(acc);
			v = (v + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS);
			tab[k] = TRIG_W'(v);
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TABLE = sin_table_init();

endpackage

>>> rtl/core/rrceh_trig.sv
module rrceh_trig (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] box_center_x,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] box_center_y,
	input  logic        [rrceh_pkg::SIZE_W-1:0]      box_width,
	input  logic        [rrceh_pkg::SIZE_W-1:0]      box_height,
	input  logic        [rrceh_pkg::ANGLE_W-1:0]     box_angle_deg,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] circle_x,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] circle_y,
	input  logic        [rrceh_pkg::SIZE_W-1:0]      circle_radius,
	output logic        [rrceh_pkg::SIZE_W-1:0]      w_s2,
	output logic        [rrceh_pkg::SIZE_W-1:0]      h_s2,
	output logic signed [rrceh_pkg::TRIG_W-1:0]      sin_s2,
	output logic signed [rrceh_pkg::TRIG_W-1:0]      cos_s2,
	output rrceh_pkg::point_t                        pc_s2,
	output logic        [rrceh_pkg::R2_W-1:0]        r2_s2
);
	import rrceh_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic [ANGLE_W-1:0]     ang_red;
	logic [1:0]             quad;
	logic [RES_W-1:0]       resid;
	logic [1:0]             quad_s1;
	logic [RES_W-1:0]       resid_s1;
	logic [SIZE_W-1:0]      w_s1;
	logic [SIZE_W-1:0]      h_s1;
	point_t                 pc_s1;
	logic [COORD_WIDTH-1:0] rad2_s1;
	logic [RES_W-1:0]       comp_idx;
	logic signed [TRIG_W-1:0] s_lo;
	logic signed [TRIG_W-1:0] s_hi;
	logic signed [TRIG_W-1:0] sin_v;
	logic signed [TRIG_W-1:0] cos_v;

	// Reduce angle to quadrant and residual
	always_comb begin
		ang_red = (box_angle_deg >= ANG_FULL) ? box_angle_deg - ANG_FULL : box_angle_deg;
		if (ang_red >= ANG_3QTR) begin
			quad  = QUAD_3;
			resid = RES_W'(ang_red - ANG_3QTR);
		end else if (ang_red >= ANG_HALF) begin
			quad  = QUAD_2;
			resid = RES_W'(ang_red - ANG_HALF);
		end else if (ang_red >= ANG_QTR) begin
			quad  = QUAD_1;
			resid = RES_W'(ang_red - ANG_QTR);
		end else begin
			quad  = QUAD_0;
			resid = RES_W'(ang_red);
		end
	end

	// Stage 1: request capture, circle center and radius in half units
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1  <= quad;
			resid_s1 <= resid;
			w_s1     <= box_width;
			h_s1     <= box_height;
			pc_s1.x  <= (PNT_W'(circle_x) - PNT_W'(box_center_x)) <<< 1;
			pc_s1.y  <= (PNT_W'(circle_y) - PNT_W'(box_center_y)) <<< 1;
			rad2_s1  <= {circle_radius, 1'b0};
		end
	end

	// Table lookup with quadrant symmetry
	always_comb begin
		comp_idx = RES_W'(QUARTER) - resid_s1;
		s_lo     = $signed(SIN_TABLE[resid_s1]);
		s_hi     = $signed(SIN_TABLE[comp_idx]);
		unique case (quad_s1)
			QUAD_0: begin sin_v = s_lo;  cos_v = s_hi;  end
			QUAD_1: begin sin_v = s_hi;  cos_v = -s_lo; end
			QUAD_2: begin sin_v = -s_lo; cos_v = -s_hi; end
			QUAD_3: begin sin_v = -s_hi; cos_v = s_lo;  end
			default: begin sin_v = s_lo; cos_v = s_hi;  end
		endcase
	end

	// Stage 2: trig values and squared radius
	always_ff @(posedge clk) begin
		if (en) begin
			sin_s2 <= sin_v;
			cos_s2 <= cos_v;
			w_s2   <= w_s1;
			h_s2   <= h_s1;
			pc_s2  <= pc_s1;
			r2_s2  <= R2_W'(rad2_s1) * R2_W'(rad2_s1);
		end
	end

endmodule

>>> rtl/core/rrceh_corners.sv
module rrceh_corners (
	input  logic                              clk,
	input  logic                              en,
	input  logic        [rrceh_pkg::SIZE_W-1:0] w_s2,
	input  logic        [rrceh_pkg::SIZE_W-1:0] h_s2,
	input  logic signed [rrceh_pkg::TRIG_W-1:0] sin_s2,
	input  logic signed [rrceh_pkg::TRIG_W-1:0] cos_s2,
	input  rrceh_pkg::point_t                   pc_s2,
	input  logic        [rrceh_pkg::R2_W-1:0]   r2_s2,
	output rrceh_pkg::point_t                   corner_s4 [4],
	output rrceh_pkg::point_t                   pc_s4,
	output logic        [rrceh_pkg::R2_W-1:0]   r2_s4
);
	import rrceh_pkg::*;

	localparam logic signed [SUMK_W-1:0] RND_HALF = SUMK_W'(1) <<< (TRIG_FRACTION_BITS - 1);

	logic signed [PROD_W-1:0] wc_s3;
	logic signed [PROD_W-1:0] ws_s3;
	logic signed [PROD_W-1:0] hc_s3;
	logic signed [PROD_W-1:0] hs_s3;
	point_t                   pc_s3;
	logic [R2_W-1:0]          r2_s3;
	logic signed [SUMK_W-1:0] wc;
	logic signed [SUMK_W-1:0] ws;
	logic signed [SUMK_W-1:0] hc;
	logic signed [SUMK_W-1:0] hs;

	// Round to nearest half unit, ties toward positive infinity
	function automatic logic signed [PNT_W-1:0] rnd_corner(input logic signed [SUMK_W-1:0] v);
		logic signed [SUMK_W-1:0] t;
		t = (v + RND_HALF) >>> TRIG_FRACTION_BITS;
		return t[PNT_W-1:0];
	endfunction

	// Stage 3: size by trig products
	always_ff @(posedge clk) begin
		if (en) begin
			wc_s3 <= $signed({1'b0, w_s2}) * cos_s2;
			ws_s3 <= $signed({1'b0, w_s2}) * sin_s2;
			hc_s3 <= $signed({1'b0, h_s2}) * cos_s2;
			hs_s3 <= $signed({1'b0, h_s2}) * sin_s2;
			pc_s3 <= pc_s2;
			r2_s3 <= r2_s2;
		end
	end

	assign wc = SUMK_W'(wc_s3);
	assign ws = SUMK_W'(ws_s3);
	assign hc = SUMK_W'(hc_s3);
	assign hs = SUMK_W'(hs_s3);

	// Stage 4: rotated corners, in order (-w,-h) (w,-h) (w,h) (-w,h)
	always_ff @(posedge clk) begin
		if (en) begin
			corner_s4[0].x <= rnd_corner(-wc + hs);
			corner_s4[0].y <= rnd_corner(-ws - hc);
			corner_s4[1].x <= rnd_corner(wc + hs);
			corner_s4[1].y <= rnd_corner(ws - hc);
			corner_s4[2].x <= rnd_corner(wc - hs);
			corner_s4[2].y <= rnd_corner(ws + hc);
			corner_s4[3].x <= rnd_corner(-wc - hs);
			corner_s4[3].y <= rnd_corner(-ws + hc);
			pc_s4          <= pc_s3;
			r2_s4          <= r2_s3;
		end
	end

endmodule

>>> rtl/core/rrceh_edge.sv
module rrceh_edge (
	input  logic                            clk,
	input  logic                            en,
	input  rrceh_pkg::point_t               st_s4,
	input  rrceh_pkg::point_t               ed_s4,
	input  rrceh_pkg::point_t               pc_s4,
	input  logic [rrceh_pkg::R2_W-1:0]      r2_s4,
	output logic                            hit_s10
);
	import rrceh_pkg::*;

	localparam int HALF_W = MAG_W / 2;
	localparam int HI_W   = MAG_W - HALF_W;
	localparam int LHS_W  = 2 * MAG_W;
	localparam int RHS_W  = R2_W + MAG_W;
	localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

	typedef struct packed {
		logic both_in;
		logic fd_le0;
		logic fd_ge_dd;
		logic ff_le;
		logic gg_le;
	} edge_flags_t;

	logic signed [DIF_W-1:0] fx_s5, fy_s5, gx_s5, gy_s5, dx_s5, dy_s5;
	logic [R2_W-1:0]         r2_s5, r2_s6, r2_s7;
	logic signed [MUL_W-1:0] fxx_s6, fyy_s6, gxx_s6, gyy_s6;
	logic signed [MUL_W-1:0] fdx_s6, fdy_s6, dxx_s6, dyy_s6, cxa_s6, cxb_s6;
	logic signed [SUM_W-1:0] ff_s7, gg_s7, fd_s7, dd_s7;
	logic [MAG_W-1:0]        acr_s7;
	logic signed [SUM_W-1:0] cross_v;
	logic signed [SUM_W-1:0] r2x;
	logic [MAG_W-1:0]        dd_mag;
	logic [2*HI_W-1:0]       p_hh_s8;
	logic [HI_W+HALF_W-1:0]  p_hl_s8;
	logic [2*HALF_W-1:0]     p_ll_s8;
	logic [R2_W+HI_W-1:0]    q_h_s8;
	logic [R2_W+HALF_W-1:0]  q_l_s8;
	edge_flags_t             flags_s8, flags_s9;
	logic [CMP_W-1:0]        lhs_s9, rhs_s9;

	// Stage 5: offsets from both ends and edge direction
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s5 <= DIF_W'(pc_s4.x) - DIF_W'(st_s4.x);
			fy_s5 <= DIF_W'(pc_s4.y) - DIF_W'(st_s4.y);
			gx_s5 <= DIF_W'(pc_s4.x) - DIF_W'(ed_s4.x);
			gy_s5 <= DIF_W'(pc_s4.y) - DIF_W'(ed_s4.y);
			dx_s5 <= DIF_W'(ed_s4.x) - DIF_W'(st_s4.x);
			dy_s5 <= DIF_W'(ed_s4.y) - DIF_W'(st_s4.y);
			r2_s5 <= r2_s4;
		end
	end

	// Stage 6: component products
	always_ff @(posedge clk) begin
		if (en) begin
			fxx_s6 <= fx_s5 * fx_s5;
			fyy_s6 <= fy_s5 * fy_s5;
			gxx_s6 <= gx_s5 * gx_s5;
			gyy_s6 <= gy_s5 * gy_s5;
			fdx_s6 <= fx_s5 * dx_s5;
			fdy_s6 <= fy_s5 * dy_s5;
			dxx_s6 <= dx_s5 * dx_s5;
			dyy_s6 <= dy_s5 * dy_s5;
			cxa_s6 <= fx_s5 * dy_s5;
			cxb_s6 <= fy_s5 * dx_s5;
			r2_s6  <= r2_s5;
		end
	end

	assign cross_v = SUM_W'(cxa_s6) - SUM_W'(cxb_s6);

	// Stage 7: squared distances, projection, length, cross magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			ff_s7  <= SUM_W'(fxx_s6) + SUM_W'(fyy_s6);
			gg_s7  <= SUM_W'(gxx_s6) + SUM_W'(gyy_s6);
			fd_s7  <= SUM_W'(fdx_s6) + SUM_W'(fdy_s6);
			dd_s7  <= SUM_W'(dxx_s6) + SUM_W'(dyy_s6);
			acr_s7 <= cross_v[SUM_W-1] ? MAG_W'(-cross_v) : MAG_W'(cross_v);
			r2_s7  <= r2_s6;
		end
	end

	assign r2x    = $signed({{(SUM_W - R2_W){1'b0}}, r2_s7});
	assign dd_mag = dd_s7[MAG_W-1:0];

	// Stage 8: region flags and split products for the distance test
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s8.both_in  <= (ff_s7 < r2x) && (gg_s7 < r2x);
			flags_s8.fd_le0   <= fd_s7[SUM_W-1] || (fd_s7 == '0);
			flags_s8.fd_ge_dd <= fd_s7 >= dd_s7;
			flags_s8.ff_le    <= ff_s7 <= r2x;
			flags_s8.gg_le    <= gg_s7 <= r2x;
			p_hh_s8 <= (2*HI_W)'(acr_s7[MAG_W-1:HALF_W]) * (2*HI_W)'(acr_s7[MAG_W-1:HALF_W]);
			p_hl_s8 <= (HI_W+HALF_W)'(acr_s7[MAG_W-1:HALF_W])
				* (HI_W+HALF_W)'(acr_s7[HALF_W-1:0]);
			p_ll_s8 <= (2*HALF_W)'(acr_s7[HALF_W-1:0]) * (2*HALF_W)'(acr_s7[HALF_W-1:0]);
			q_h_s8  <= (R2_W+HI_W)'(r2_s7) * (R2_W+HI_W)'(dd_mag[MAG_W-1:HALF_W]);
			q_l_s8  <= (R2_W+HALF_W)'(r2_s7) * (R2_W+HALF_W)'(dd_mag[HALF_W-1:0]);
		end
	end

	// Stage 9: recombine cross^2 and r2*dd
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s9 <= flags_s8;
			lhs_s9   <= (CMP_W'(p_hh_s8) << (2 * HALF_W)) + (CMP_W'(p_hl_s8) << (HALF_W + 1))
				+ CMP_W'(p_ll_s8);
			rhs_s9   <= (CMP_W'(q_h_s8) << HALF_W) + CMP_W'(q_l_s8);
		end
	end

	// Stage 10: edge decision
	always_ff @(posedge clk) begin
		if (en) begin
			if (flags_s9.both_in) begin
				hit_s10 <= 1'b0;
			end else if (flags_s9.fd_le0) begin
				hit_s10 <= flags_s9.ff_le;
			end else if (flags_s9.fd_ge_dd) begin
				hit_s10 <= flags_s9.gg_le;
			end else begin
				hit_s10 <= lhs_s9 <= rhs_s9;
			end
		end
	end

endmodule

>>> rtl/core/rotated_rect_circle_edge_hit.sv
// Rotated rectangle edges against a circle boundary.
// A request passes through ten register stages (s1 to s10) from accept to result valid.
// Throughput: one request per cycle; a stall at the output holds every stage.
// The widest stage is the split 38-bit square against radius^2 * length^2 test.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
module rotated_rect_circle_edge_hit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] box_center_x,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] box_center_y,
	input  logic        [rrceh_pkg::SIZE_W-1:0]      box_width,
	input  logic        [rrceh_pkg::SIZE_W-1:0]      box_height,
	input  logic        [rrceh_pkg::ANGLE_W-1:0]     box_angle_deg,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] circle_x,
	input  logic signed [rrceh_pkg::COORD_WIDTH-1:0] circle_y,
	input  logic        [rrceh_pkg::SIZE_W-1:0]      circle_radius,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     hit
);
	import rrceh_pkg::*;

	`include "rotated_rect_circle_edge_hit_defines.svh"

	logic                   en;
	logic [PIPE_DEPTH-1:0]  valid_q;
	logic [SIZE_W-1:0]      w_s2;
	logic [SIZE_W-1:0]      h_s2;
	logic signed [TRIG_W-1:0] sin_s2;
	logic signed [TRIG_W-1:0] cos_s2;
	point_t                 pc_s2;
	logic [R2_W-1:0]        r2_s2;
	point_t                 corner_s4 [4];
	point_t                 pc_s4;
	logic [R2_W-1:0]        r2_s4;
	logic [3:0]             edge_hit_s10;

	// Whole pipe advances unless the result is held
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = valid_q[PIPE_DEPTH-1];
	assign hit       = |edge_hit_s10;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	rrceh_trig u_trig (
		.clk           (clk),
		.en            (en),
		.box_center_x  (box_center_x),
		.box_center_y  (box_center_y),
		.box_width     (box_width),
		.box_height    (box_height),
		.box_angle_deg (box_angle_deg),
		.circle_x      (circle_x),
		.circle_y      (circle_y),
		.circle_radius (circle_radius),
		.w_s2          (w_s2),
		.h_s2          (h_s2),
		.sin_s2        (sin_s2),
		.cos_s2        (cos_s2),
		.pc_s2         (pc_s2),
		.r2_s2         (r2_s2)
	);

	rrceh_corners u_corners (
		.clk       (clk),
		.en        (en),
		.w_s2      (w_s2),
		.h_s2      (h_s2),
		.sin_s2    (sin_s2),
		.cos_s2    (cos_s2),
		.pc_s2     (pc_s2),
		.r2_s2     (r2_s2),
		.corner_s4 (corner_s4),
		.pc_s4     (pc_s4),
		.r2_s4     (r2_s4)
	);

	// One test lane per edge, corner i to corner i+1
	for (genvar i = 0; i < 4; i++) begin : g_edge
		rrceh_edge u_edge (
			.clk     (clk),
			.en      (en),
			.st_s4   (corner_s4[i]),
			.ed_s4   (corner_s4[(i + 1) % 4]),
			.pc_s4   (pc_s4),
			.r2_s4   (r2_s4),
			.hit_s10 (edge_hit_s10[i])
		);
	end

	`RRCEH_ASSERT_IMP(a_stall_only_when_held, clk, arst_n, in_stall, out_valid)
	`RRCEH_ASSERT_NXT(a_accept_enters_s1, clk, arst_n, in_valid && !in_stall, valid_q[0])
	`RRCEH_ASSERT_NXT(a_valid_shift, clk, arst_n, en,
		valid_q[PIPE_DEPTH-1:1] == $past(valid_q[PIPE_DEPTH-2:0]))
	`RRCEH_ASSERT_NXT(a_valid_hold, clk, arst_n, !en, $stable(valid_q))

endmodule
